@@ sv/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/cdll_pkg.sv @@
// Types, codes and helpers shared by the linked list manager modules.
package cdll_pkg;

    localparam int NODE_SLOTS = 64;
    localparam int LIST_COUNT = 4;
    localparam int NODE_W     = 6;
    localparam int LIST_W     = 2;
    localparam int CNT_W      = 7;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [LIST_W-1:0] list_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [2:0]        cmd_t;

    localparam cmd_t CMD_APPEND     = 3'd0;
    localparam cmd_t CMD_INS_AFTER  = 3'd1;
    localparam cmd_t CMD_INS_BEFORE = 3'd2;
    localparam cmd_t CMD_REMOVE     = 3'd3;
    localparam cmd_t CMD_POP        = 3'd4;
    localparam cmd_t CMD_QUERY      = 3'd5;

    typedef struct packed {
        cmd_t  cmd;
        list_t list_sel;
        node_t node_id;
        node_t anchor_id;
    } cdll_in_t;

    typedef struct packed {
        logic  status;
        node_t popped_node;
        logic  popped_valid;
        node_t head_node;
        node_t tail_node;
        logic  list_empty;
        cnt_t  list_count;
        node_t next_node;
        logic  next_valid;
        node_t prev_node;
        logic  prev_valid;
    } cdll_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LINK,
        ST_READ,
        ST_REPORT
    } cdll_state_t;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic take;
        logic exec;
        logic link;
        logic rd;
        logic load;
    } cdll_ctl_t;

    function automatic logic node_in_range(node_t id);
        return int'(id) < NODE_SLOTS;
    endfunction

    function automatic logic list_in_range(list_t id);
        return int'(id) < LIST_COUNT;
    endfunction

endpackage

@@ sv/cdll_ctrl.sv @@
// Sequencing state machine and result handshake for the linked list manager.
module cdll_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output cdll_pkg::cdll_ctl_t ctl
);
    import cdll_pkg::*;

    cdll_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.take   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ctl.exec   = 1'b1;
                state_next = ST_LINK;
            end
            ST_LINK: begin
                ctl.link   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                ctl.rd     = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    ctl.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = m_valid_reg && !m_ready;
        if (ctl.load) begin
            m_valid_next = 1'b1;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ sv/cdll_dpath.sv @@
// Link memories, list registers and result register of the linked list manager.
module cdll_dpath (
    input  logic                aclk,
    input  logic                aresetn,
    input  cdll_pkg::cdll_ctl_t ctl,
    input  cdll_pkg::cdll_in_t  s_data,
    output cdll_pkg::cdll_out_t m_data
);
    import cdll_pkg::*;

    // link memories
    node_t next_mem [NODE_SLOTS];
    node_t prev_mem [NODE_SLOTS];
    list_t own_mem  [NODE_SLOTS];

    logic [NODE_SLOTS-1:0] ov_reg;
    node_t head_reg  [LIST_COUNT];
    node_t tail_reg  [LIST_COUNT];
    cnt_t  count_reg [LIST_COUNT];

    cmd_t  cmd_reg;
    list_t lsel_reg;
    node_t node_reg;
    node_t anchor_reg;
    node_t tgt_reg;
    list_t rl_reg;
    logic  status_reg;
    logic  pop_v_reg;

    list_t own_a_reg, own_b_reg;
    node_t nxt_a_reg, nxt_b_reg;
    node_t prv_a_reg, prv_b_reg;

    logic  w2n_en_reg, w2p_en_reg;
    node_t w2n_addr_reg, w2n_data_reg;
    node_t w2p_addr_reg, w2p_data_reg;

    cdll_out_t out_reg;

    list_t ol, lidx, rl;
    node_t l_head, l_tail, take_tgt, rb_addr;
    cnt_t  l_cnt, cnt_val;
    logic  ok, unlink, pop_v;
    logic  w1_en, ov_set, ov_clr, hd_we, tl_we, cnt_we;
    node_t w1_next, w1_prev, hd_val, tl_val;
    logic  w2n_en, w2p_en;
    node_t w2n_addr, w2n_data, w2p_addr, w2p_data;
    logic  ov_node, anc_ok, node_free;

    logic  nm_we, pm_we;
    node_t nm_wa, nm_wd, pm_wa, pm_wd;

    cdll_out_t res;
    logic  r_list_ok, r_any, r_owned;
    cnt_t  r_cnt;

    // Inserts work on the anchor's list, everything else on list_sel.
    assign ol = (cmd_reg == CMD_INS_AFTER || cmd_reg == CMD_INS_BEFORE) ? own_a_reg : lsel_reg;

    assign lidx   = ctl.exec ? ol : (ctl.take ? s_data.list_sel : rl_reg);
    assign l_head = head_reg[lidx];
    assign l_tail = tail_reg[lidx];
    assign l_cnt  = count_reg[lidx];

    assign take_tgt = (s_data.cmd == CMD_POP) ? l_head : s_data.node_id;
    assign rb_addr  = ctl.rd ? node_reg : take_tgt;

    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            cmd_reg    <= s_data.cmd;
            lsel_reg   <= s_data.list_sel;
            node_reg   <= s_data.node_id;
            anchor_reg <= s_data.anchor_id;
            tgt_reg    <= take_tgt;
            own_a_reg  <= own_mem[s_data.anchor_id];
            nxt_a_reg  <= next_mem[s_data.anchor_id];
            prv_a_reg  <= prev_mem[s_data.anchor_id];
        end
        if (ctl.take || ctl.rd) begin
            own_b_reg <= own_mem[rb_addr];
            nxt_b_reg <= next_mem[rb_addr];
            prv_b_reg <= prev_mem[rb_addr];
        end
    end

    assign ov_node   = ov_reg[node_reg];
    assign node_free = node_in_range(node_reg) && !ov_node;
    assign anc_ok    = node_in_range(anchor_reg) && ov_reg[anchor_reg];

    always_comb begin
        ok       = 1'b0;
        unlink   = 1'b0;
        pop_v    = 1'b0;
        rl       = lsel_reg;
        w1_en    = 1'b0;
        w1_next  = node_reg;
        w1_prev  = node_reg;
        ov_set   = 1'b0;
        ov_clr   = 1'b0;
        hd_we    = 1'b0;
        hd_val   = node_reg;
        tl_we    = 1'b0;
        tl_val   = node_reg;
        cnt_we   = 1'b0;
        cnt_val  = l_cnt;
        w2n_en   = 1'b0;
        w2n_addr = node_reg;
        w2n_data = node_reg;
        w2p_en   = 1'b0;
        w2p_addr = node_reg;
        w2p_data = node_reg;
        case (cmd_reg)
            CMD_APPEND: begin
                if (list_in_range(lsel_reg) && node_free) begin
                    ok      = 1'b1;
                    w1_en   = 1'b1;
                    ov_set  = 1'b1;
                    cnt_we  = 1'b1;
                    cnt_val = l_cnt + cnt_t'(1);
                    tl_we   = 1'b1;
                    if (l_cnt == '0) begin
                        hd_we = 1'b1;
                    end else begin
                        w1_next  = l_head;
                        w1_prev  = l_tail;
                        w2n_en   = 1'b1;
                        w2n_addr = l_tail;
                        w2p_en   = 1'b1;
                        w2p_addr = l_head;
                    end
                end
            end
            CMD_INS_AFTER: begin
                if (anc_ok) begin
                    rl = own_a_reg;
                    if (node_free) begin
                        ok       = 1'b1;
                        w1_en    = 1'b1;
                        w1_next  = nxt_a_reg;
                        w1_prev  = anchor_reg;
                        ov_set   = 1'b1;
                        cnt_we   = 1'b1;
                        cnt_val  = l_cnt + cnt_t'(1);
                        w2n_en   = 1'b1;
                        w2n_addr = anchor_reg;
                        w2p_en   = 1'b1;
                        w2p_addr = nxt_a_reg;
                        tl_we    = (l_tail == anchor_reg);
                    end
                end
            end
            CMD_INS_BEFORE: begin
                if (anc_ok) begin
                    rl = own_a_reg;
                    if (node_free) begin
                        ok       = 1'b1;
                        w1_en    = 1'b1;
                        w1_next  = anchor_reg;
                        w1_prev  = prv_a_reg;
                        ov_set   = 1'b1;
                        cnt_we   = 1'b1;
                        cnt_val  = l_cnt + cnt_t'(1);
                        w2n_en   = 1'b1;
                        w2n_addr = prv_a_reg;
                        w2p_en   = 1'b1;
                        w2p_addr = anchor_reg;
                        hd_we    = (l_head == anchor_reg);
                    end
                end
            end
            CMD_REMOVE: begin
                if (list_in_range(lsel_reg) && node_in_range(node_reg) && ov_node
                        && own_b_reg == lsel_reg && l_cnt != '0) begin
                    ok     = 1'b1;
                    unlink = 1'b1;
                end
            end
            CMD_POP: begin
                if (list_in_range(lsel_reg) && l_cnt != '0) begin
                    ok     = 1'b1;
                    unlink = 1'b1;
                    pop_v  = 1'b1;
                end
            end
            CMD_QUERY: begin
                ok = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        // unlink tgt from its list; a last node just drops the count
        if (unlink) begin
            ov_clr = 1'b1;
            cnt_we = 1'b1;
            if (l_cnt <= cnt_t'(1)) begin
                cnt_val = '0;
            end else begin
                cnt_val  = l_cnt - cnt_t'(1);
                w2n_en   = 1'b1;
                w2n_addr = prv_b_reg;
                w2n_data = nxt_b_reg;
                w2p_en   = 1'b1;
                w2p_addr = nxt_b_reg;
                w2p_data = prv_b_reg;
                hd_we    = (l_head == tgt_reg);
                hd_val   = nxt_b_reg;
                tl_we    = (l_tail == tgt_reg);
                tl_val   = prv_b_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.exec) begin
            rl_reg       <= rl;
            status_reg   <= !ok;
            pop_v_reg    <= pop_v;
            w2n_en_reg   <= w2n_en;
            w2n_addr_reg <= w2n_addr;
            w2n_data_reg <= w2n_data;
            w2p_en_reg   <= w2p_en;
            w2p_addr_reg <= w2p_addr;
            w2p_data_reg <= w2p_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LIST_COUNT; i++) begin
                count_reg[i] <= '0;
            end
            ov_reg <= '0;
        end else if (ctl.exec) begin
            if (cnt_we) begin
                count_reg[ol] <= cnt_val;
            end
            if (ov_set) begin
                ov_reg[node_reg] <= 1'b1;
            end
            if (ov_clr) begin
                ov_reg[tgt_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.exec && hd_we) begin
            head_reg[ol] <= hd_val;
        end
        if (ctl.exec && tl_we) begin
            tail_reg[ol] <= tl_val;
        end
    end

    // New node's own links are written in the execute step, neighbor links in the link step right after it.
    assign nm_we = (ctl.exec && w1_en) || (ctl.link && w2n_en_reg);
    assign nm_wa = ctl.exec ? node_reg : w2n_addr_reg;
    assign nm_wd = ctl.exec ? w1_next : w2n_data_reg;
    assign pm_we = (ctl.exec && w1_en) || (ctl.link && w2p_en_reg);
    assign pm_wa = ctl.exec ? node_reg : w2p_addr_reg;
    assign pm_wd = ctl.exec ? w1_prev : w2p_data_reg;

    always_ff @(posedge aclk) begin
        if (nm_we) begin
            next_mem[nm_wa] <= nm_wd;
        end
        if (pm_we) begin
            prev_mem[pm_wa] <= pm_wd;
        end
        if (ctl.exec && w1_en) begin
            own_mem[node_reg] <= ol;
        end
    end

    always_comb begin
        r_list_ok = list_in_range(rl_reg);
        r_cnt     = r_list_ok ? l_cnt : '0;
        r_any     = (r_cnt != '0);
        r_owned   = r_list_ok && node_in_range(node_reg) && ov_node && own_b_reg == rl_reg;
        res              = '0;
        res.status       = status_reg;
        res.popped_valid = pop_v_reg;
        res.popped_node  = pop_v_reg ? tgt_reg : '0;
        res.list_count   = r_cnt;
        res.list_empty   = !r_any;
        if (r_any) begin
            res.head_node = l_head;
            res.tail_node = l_tail;
        end
        if (r_any && r_owned && node_reg != l_tail) begin
            res.next_node  = nxt_b_reg;
            res.next_valid = 1'b1;
        end
        if (r_any && r_owned && node_reg != l_head) begin
            res.prev_node  = prv_b_reg;
            res.prev_valid = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            out_reg <= res;
        end
    end

    assign m_data = out_reg;

endmodule

@@ sv/circular_doubly_linked_list_manager_unit.sv @@
// Top level of the circular doubly linked list manager.
// Commands are taken one at a time and pass the steps accept, execute, relink, read back, report;
// the sequencing is set by the single write port of each link memory and the registered read-back.
// The result beat shows on m_valid once the report step can load the output register;
// the output register lets the next command in while that beat waits.
// Reset (aresetn low, synchronous) empties every list and frees every node slot at once.
module circular_doubly_linked_list_manager_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cdll_pkg::cdll_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cdll_pkg::cdll_out_t m_data
);
    import cdll_pkg::*;

    // Command bundle from the sequencer to the datapath.
    cdll_ctl_t ctl;

    // Sequencer: take a beat, run it through the datapath steps, then
    // drop the result into the output register once it is free.
    cdll_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    // Datapath: link memories (next, prev, owner), per-list head, tail and
    // count registers, node ownership flags, and the result register.
    cdll_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

@@ sv/cdll_checker.sv @@
// Port-level checker for the linked list manager, bound to the top level.
`include "assert_macros.svh"

module cdll_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input cdll_pkg::cdll_out_t m_data
);
    import cdll_pkg::*;

    logic count_zero;
    logic ends_clear;

    assign count_zero = (m_data.list_count == '0);
    assign ends_clear = !m_data.next_valid && !m_data.prev_valid
                        && m_data.head_node == '0 && m_data.tail_node == '0;

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // one command in flight: input closes right after a beat is taken
    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // empty flag agrees with the count
    `ASSERT_IMPLIES(a_empty_count, aclk, aresetn, m_valid, m_data.list_empty == count_zero)

    // an empty list reports no ends and no neighbors
    `ASSERT_IMPLIES(a_empty_clean, aclk, aresetn, m_valid && m_data.list_empty, ends_clear)

    // a popped node only comes with a completed operation
    `ASSERT_IMPLIES(a_pop_status, aclk, aresetn, m_valid && m_data.popped_valid, !m_data.status)

endmodule

bind circular_doubly_linked_list_manager_unit cdll_checker u_cdll_checker (.*);

@@ verif/cdll_list_scoreboard.sv @@
// Scoreboard for the linked list manager: list state tracking and result beat checks.
`timescale 1ns / 100ps
package cdll_tb_pkg;
    import cdll_pkg::*;

    // Command codes that the block has no operation for.
    localparam cmd_t CMD_SPARE6 = 3'd6;
    localparam cmd_t CMD_SPARE7 = 3'd7;

    class list_scoreboard;
        node_t     link_next [NODE_SLOTS];
        node_t     link_prev [NODE_SLOTS];
        bit        slot_owned [NODE_SLOTS];
        list_t     slot_list [NODE_SLOTS];
        node_t     list_head [LIST_COUNT];
        node_t     list_tail [LIST_COUNT];
        cnt_t      list_len [LIST_COUNT];
        cdll_out_t expected_reports [$];
        int        errors;
        int        reports_checked;
        int        refused_cmds;
        int        peak_len;
        int        done_by_cmd [8];

        function new();
            foreach (link_next[i]) begin
                link_next[i]  = '0;
                link_prev[i]  = '0;
                slot_owned[i] = 1'b0;
                slot_list[i]  = '0;
            end
            foreach (list_head[i]) begin
                list_head[i] = '0;
                list_tail[i] = '0;
                list_len[i]  = '0;
            end
            foreach (done_by_cmd[i]) done_by_cmd[i] = 0;
            errors          = 0;
            reports_checked = 0;
            refused_cmds    = 0;
            peak_len        = 0;
        endfunction

        function void splice_after(node_t a, node_t n);
            list_t l;
            node_t x;
            l = slot_list[a];
            x = link_next[a];
            link_next[n] = x;
            link_prev[n] = a;
            link_prev[x] = n;
            link_next[a] = n;
            if (list_tail[l] == a) list_tail[l] = n;
            slot_owned[n] = 1'b1;
            slot_list[n]  = l;
            list_len[l]   = list_len[l] + 1'b1;
        endfunction

        function void splice_before(node_t a, node_t n);
            list_t l;
            node_t p;
            l = slot_list[a];
            p = link_prev[a];
            link_prev[n] = p;
            link_next[n] = a;
            link_next[p] = n;
            link_prev[a] = n;
            if (list_head[l] == a) list_head[l] = n;
            slot_owned[n] = 1'b1;
            slot_list[n]  = l;
            list_len[l]   = list_len[l] + 1'b1;
        endfunction

        function void detach(list_t l, node_t n);
            node_t p;
            node_t x;
            if (list_len[l] <= 1) begin
                list_len[l]  = '0;
                list_head[l] = '0;
                list_tail[l] = '0;
            end else begin
                p = link_prev[n];
                x = link_next[n];
                link_next[p] = x;
                link_prev[x] = p;
                if (list_head[l] == n) list_head[l] = x;
                if (list_tail[l] == n) list_tail[l] = p;
                list_len[l] = list_len[l] - 1'b1;
            end
            slot_owned[n] = 1'b0;
            slot_list[n]  = '0;
            link_next[n]  = '0;
            link_prev[n]  = '0;
        endfunction

        // Update the lists for one command and build the result beat it must produce.
        function cdll_out_t apply_command(cdll_in_t c);
            cdll_out_t r;
            list_t     rl;
            node_t     n;
            node_t     a;
            node_t     h;
            r = '0;
            r.status = 1'b1;
            rl = c.list_sel;
            n  = c.node_id;
            a  = c.anchor_id;
            case (c.cmd)
                CMD_APPEND: begin
                    if (!slot_owned[n]) begin
                        if (list_len[rl] == 0) begin
                            list_head[rl] = n;
                            list_tail[rl] = n;
                            link_next[n]  = n;
                            link_prev[n]  = n;
                            slot_owned[n] = 1'b1;
                            slot_list[n]  = rl;
                            list_len[rl]  = cnt_t'(1);
                        end else begin
                            splice_after(list_tail[rl], n);
                        end
                        r.status = 1'b0;
                    end
                end
                CMD_INS_AFTER, CMD_INS_BEFORE: begin
                    if (slot_owned[a]) begin
                        rl = slot_list[a];
                        if (!slot_owned[n]) begin
                            if (c.cmd == CMD_INS_AFTER) splice_after(a, n);
                            else splice_before(a, n);
                            r.status = 1'b0;
                        end
                    end
                end
                CMD_REMOVE: begin
                    if (slot_owned[n] && slot_list[n] == rl && list_len[rl] > 0) begin
                        detach(rl, n);
                        r.status = 1'b0;
                    end
                end
                CMD_POP: begin
                    if (list_len[rl] > 0) begin
                        h = list_head[rl];
                        detach(rl, h);
                        r.popped_node  = h;
                        r.popped_valid = 1'b1;
                        r.status       = 1'b0;
                    end
                end
                CMD_QUERY: r.status = 1'b0;
                default: ;
            endcase

            r.list_count = list_len[rl];
            r.list_empty = (list_len[rl] == 0);
            if (list_len[rl] > 0) begin
                r.head_node = list_head[rl];
                r.tail_node = list_tail[rl];
                if (slot_owned[n] && slot_list[n] == rl) begin
                    if (n != list_tail[rl]) begin
                        r.next_node  = link_next[n];
                        r.next_valid = 1'b1;
                    end
                    if (n != list_head[rl]) begin
                        r.prev_node  = link_prev[n];
                        r.prev_valid = 1'b1;
                    end
                end
            end

            if (r.status) refused_cmds++;
            else done_by_cmd[c.cmd]++;
            if (int'(list_len[rl]) > peak_len) peak_len = int'(list_len[rl]);
            return r;
        endfunction

        function void note_command(cdll_in_t c);
            expected_reports.push_back(apply_command(c));
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                errors++;
            end
        endfunction

        function void check_report(cdll_out_t got);
            cdll_out_t want;
            if (expected_reports.size() == 0) begin
                $error("result beat with no command outstanding");
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            reports_checked++;
            compare_field("status",       32'(want.status),       32'(got.status));
            compare_field("popped_node",  32'(want.popped_node),  32'(got.popped_node));
            compare_field("popped_valid", 32'(want.popped_valid), 32'(got.popped_valid));
            compare_field("head_node",    32'(want.head_node),    32'(got.head_node));
            compare_field("tail_node",    32'(want.tail_node),    32'(got.tail_node));
            compare_field("list_empty",   32'(want.list_empty),   32'(got.list_empty));
            compare_field("list_count",   32'(want.list_count),   32'(got.list_count));
            compare_field("next_node",    32'(want.next_node),    32'(got.next_node));
            compare_field("next_valid",   32'(want.next_valid),   32'(got.next_valid));
            compare_field("prev_node",    32'(want.prev_node),    32'(got.prev_node));
            compare_field("prev_valid",   32'(want.prev_valid),   32'(got.prev_valid));
        endfunction
    endclass

endpackage

@@ verif/tb.sv @@
// Testbench top for the circular doubly linked list manager unit.
`timescale 1ns / 100ps
module tb;
    import cdll_pkg::*;
    import cdll_tb_pkg::*;

    // Random part: SEGMENTS stretches of SEG_ITEMS commands, each with its own idling and mix.
    localparam int SEGMENTS    = 7;
    localparam int SEG_ITEMS   = 250;
    localparam int LONG_HOLD   = 300;     // receiver stall that backs the block up
    localparam int DRAIN_WAIT  = 20;      // idle margin after the last result is checked
    localparam int CYCLE_LIMIT = 200000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    cdll_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    cdll_out_t m_data;

    list_scoreboard sb;
    bit tx_idle_on    = 1'b0;
    bit rx_idle_on    = 1'b0;
    bit long_hold_req = 1'b0;
    int cycles        = 0;

    circular_doubly_linked_list_manager_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Bound the run; a hung handshake ends here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic cdll_in_t make_cmd(cmd_t cmd, list_t lsel, node_t node, node_t anchor);
        cdll_in_t c;
        c.cmd       = cmd;
        c.list_sel  = lsel;
        c.node_id   = node;
        c.anchor_id = anchor;
        return c;
    endfunction

    // Build one random command from the current list state. Most commands are
    // well formed (free node to insert, owned node to remove) so the lists grow
    // deep; a slice is pure noise, unused codes included. In focus mode the
    // commands pile every node into one list to reach a full list.
    function automatic cdll_in_t make_random_command(bit focus_on, list_t focus);
        cdll_in_t c;
        int       roll;
        int       used;
        int       grow_pct;
        int       i;
        node_t    probe;
        node_t    free_n;
        node_t    own_n;
        bit       have_free;
        bit       have_own;
        c.cmd       = cmd_t'($urandom_range(0, 7));
        c.list_sel  = list_t'($urandom_range(0, LIST_COUNT - 1));
        c.node_id   = node_t'($urandom_range(0, NODE_SLOTS - 1));
        c.anchor_id = node_t'($urandom_range(0, NODE_SLOTS - 1));
        used      = 0;
        have_free = 1'b0;
        have_own  = 1'b0;
        free_n    = '0;
        own_n     = '0;
        // Scan all slots from a random start; take the first free and owned ones.
        probe = node_t'($urandom_range(0, NODE_SLOTS - 1));
        for (i = 0; i < NODE_SLOTS; i++) begin
            if (sb.slot_owned[probe]) begin
                used++;
                if (!have_own) begin
                    own_n    = probe;
                    have_own = 1'b1;
                end
            end else if (!have_free) begin
                free_n    = probe;
                have_free = 1'b1;
            end
            probe = probe + 1'b1;
        end

        roll = $urandom_range(0, 99);
        if (roll < 8) return c;

        if (focus_on) begin
            if (have_free && roll < 80) begin
                c.cmd      = CMD_APPEND;
                c.list_sel = focus;
                c.node_id  = free_n;
            end else begin
                // Drain the other lists first; once the focus list holds
                // everything, pop its head so appends keep landing.
                c.cmd      = CMD_POP;
                c.list_sel = focus;
                for (i = 0; i < LIST_COUNT; i++) begin
                    if (list_t'(i) != focus && sb.list_len[i] != 0) c.list_sel = list_t'(i);
                end
            end
            return c;
        end

        grow_pct = (used < 16) ? 75 : ((used > 48) ? 25 : 55);
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            c.cmd = CMD_QUERY;
            if (have_own && roll < 7) begin
                c.node_id  = own_n;
                c.list_sel = sb.slot_list[own_n];
            end
        end else if (have_free && $urandom_range(0, 99) < grow_pct) begin
            c.node_id = free_n;
            if (!have_own || roll < 40) begin
                c.cmd = CMD_APPEND;
            end else begin
                c.cmd       = (roll < 70) ? CMD_INS_AFTER : CMD_INS_BEFORE;
                c.anchor_id = own_n;
            end
        end else if (have_own && roll < 60) begin
            c.cmd      = CMD_REMOVE;
            c.node_id  = own_n;
            c.list_sel = sb.slot_list[own_n];
        end else begin
            c.cmd = CMD_POP;
        end
        return c;
    endfunction

    // Offer one command beat and hold it until the block takes it.
    task automatic offer_command(cdll_in_t c);
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(c);
    endtask

    // Result side: check every accepted beat, then decide next cycle's ready.
    initial begin : result_sink
        int hold_left;
        bit long_hold_done;
        hold_left      = 0;
        long_hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_report(m_data);
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                // drop ready for a burst of random length, counted down in hold_left
                m_ready <= 1'b0;
                hold_left = $urandom_range(0, 4);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        cdll_in_t directed [$];
        int       seg;
        int       k;
        bit       focus_on;
        list_t    focus;
        sb = new();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opener: guards on empty lists, inserts at both ends and in
        // the middle, refused inserts of owned nodes and with a free anchor,
        // removes from the wrong list, unused codes, then removes and pops, leaving two nodes in list 0.
        directed.push_back(make_cmd(CMD_POP,        2'd0, 6'd0,  6'd0));
        directed.push_back(make_cmd(CMD_REMOVE,     2'd1, 6'd5,  6'd0));
        directed.push_back(make_cmd(CMD_INS_AFTER,  2'd2, 6'd8,  6'd7));
        directed.push_back(make_cmd(CMD_APPEND,     2'd0, 6'd0,  6'd63));
        directed.push_back(make_cmd(CMD_APPEND,     2'd0, 6'd63, 6'd0));
        directed.push_back(make_cmd(CMD_INS_AFTER,  2'd3, 6'd10, 6'd63));
        directed.push_back(make_cmd(CMD_INS_BEFORE, 2'd1, 6'd20, 6'd0));
        directed.push_back(make_cmd(CMD_INS_AFTER,  2'd0, 6'd42, 6'd0));
        directed.push_back(make_cmd(CMD_INS_BEFORE, 2'd0, 6'd21, 6'd42));
        directed.push_back(make_cmd(CMD_APPEND,     2'd0, 6'd63, 6'd0));
        directed.push_back(make_cmd(CMD_APPEND,     2'd3, 6'd0,  6'd0));
        directed.push_back(make_cmd(CMD_INS_AFTER,  2'd0, 6'd42, 6'd0));
        directed.push_back(make_cmd(CMD_APPEND,     2'd3, 6'd33, 6'd21));
        directed.push_back(make_cmd(CMD_REMOVE,     2'd3, 6'd0,  6'd0));
        directed.push_back(make_cmd(CMD_QUERY,      2'd0, 6'd21, 6'd0));
        directed.push_back(make_cmd(CMD_QUERY,      2'd0, 6'd20, 6'd0));
        directed.push_back(make_cmd(CMD_QUERY,      2'd2, 6'd5,  6'd0));
        directed.push_back(make_cmd(CMD_SPARE6,     2'd1, 6'd63, 6'd63));
        directed.push_back(make_cmd(CMD_SPARE7,     2'd0, 6'd0,  6'd0));
        directed.push_back(make_cmd(CMD_REMOVE,     2'd0, 6'd42, 6'd0));
        directed.push_back(make_cmd(CMD_REMOVE,     2'd0, 6'd20, 6'd0));
        directed.push_back(make_cmd(CMD_REMOVE,     2'd0, 6'd10, 6'd0));
        directed.push_back(make_cmd(CMD_POP,        2'd0, 6'd0,  6'd0));
        directed.push_back(make_cmd(CMD_REMOVE,     2'd3, 6'd33, 6'd0));
        directed.push_back(make_cmd(CMD_POP,        2'd3, 6'd33, 6'd0));
        foreach (directed[i]) offer_command(directed[i]);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            // Segment 1 and the last one run with no idling on either side.
            tx_idle_on = (seg != 1) && (seg != SEGMENTS - 1);
            rx_idle_on = tx_idle_on;
            focus_on   = (seg == 2) || (seg == 5);
            focus      = (seg == 2) ? list_t'(0) : list_t'(LIST_COUNT - 1);
            if (seg == 3) long_hold_req = 1'b1;
            if (seg == 4) begin
                // Pause the sender until every outstanding result has drained.
                s_valid <= 1'b0;
                do @(posedge aclk); while (sb.pending() != 0);
            end
            for (k = 0; k < SEG_ITEMS; k++) begin
                if (tx_idle_on && $urandom_range(0, 4) == 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge aclk);
                end
                offer_command(make_random_command(focus_on, focus));
            end
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Run covered %0d result beats: %0d appends, %0d inserts, %0d removes, %0d pops,",
                 sb.reports_checked, sb.done_by_cmd[CMD_APPEND],
                 sb.done_by_cmd[CMD_INS_AFTER] + sb.done_by_cmd[CMD_INS_BEFORE],
                 sb.done_by_cmd[CMD_REMOVE], sb.done_by_cmd[CMD_POP]);
        $display("%0d queries and %0d refused commands; longest list held %0d nodes.",
                 sb.done_by_cmd[CMD_QUERY], sb.refused_cmds, sb.peak_len);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/cdll_pkg.sv
sv/cdll_ctrl.sv
sv/cdll_dpath.sv
sv/circular_doubly_linked_list_manager_unit.sv
sv/cdll_checker.sv
verif/cdll_list_scoreboard.sv
verif/tb.sv
